### hw/rtl/dbpr_pkg.sv
package dbpr_pkg;

  // Default frame geometry
  localparam int unsigned DepthWidthDef  = 640;
  localparam int unsigned DepthHeightDef = 480;
  localparam int unsigned ColorWidthDef  = 1280;
  localparam int unsigned ColorHeightDef = 960;

  // Port field widths
  localparam int unsigned RowInW = 9;
  localparam int unsigned ColInW = 10;
  localparam int unsigned DepthW = 16;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned PosW   = 21;

  localparam logic [CfgW-1:0] DepthMaxReset = 13'd100;

  // Camera constants, focal length in tenths of a pixel
  localparam int unsigned FocalTenths  = 5758;
  localparam int unsigned ColorRatio   = 5250;
  localparam int unsigned BaselineTerm = 26250;
  localparam int unsigned PosScale     = 80;
  localparam int unsigned PosLimit     = 600000;

  // Color numerators reduce to step*index + offset*(size-1), never negative
  localparam int unsigned ColStep     = 2 * ColorRatio;
  localparam int unsigned CenterStep  = FocalTenths - ColorRatio;
  localparam int unsigned BaselineNum = BaselineTerm * FocalTenths;
  localparam int unsigned RoundBias   = FocalTenths / 2;

  // Position path widths
  localparam int unsigned MagW    = 12;  // |2*idx - (size-1)|
  localparam int unsigned ProdW   = 28;  // magnitude * depth
  localparam int unsigned ScaledW = 35;  // *80 + rounding bias
  localparam int unsigned NarrowW = 32;  // scaled value below saturation
  localparam int unsigned QPosW   = 20;  // unsigned rounded position

  localparam logic [ScaledW-1:0] SatThresh =
    ScaledW'(64'(PosLimit + 1) * 64'(FocalTenths));

  // Reciprocal of 5758 exact for 32-bit dividends
  localparam int unsigned RecipPosW     = 33;
  localparam int unsigned RecipPosShift = 45;
  localparam logic [RecipPosW-1:0] RecipPos =
    RecipPosW'(((64'd1 << RecipPosShift) + 64'(FocalTenths) - 64'd1) / 64'(FocalTenths));

  // Color row path: reciprocal exact for 23-bit dividends
  localparam int unsigned NumrW         = 23;
  localparam int unsigned RecipRowW     = 24;
  localparam int unsigned RecipRowShift = 36;
  localparam int unsigned RowProdW      = NumrW + RecipRowW;
  localparam int unsigned CrW           = 11;
  localparam logic [RecipRowW-1:0] RecipRow =
    RecipRowW'(((64'd1 << RecipRowShift) + 64'(FocalTenths) - 64'd1) / 64'(FocalTenths));

  // Color column path: numerator over 5758*depth
  localparam int unsigned AW    = 24;
  localparam int unsigned NumcW = 40;
  localparam int unsigned DenW  = 29;
  localparam int unsigned DivW  = 42;
  localparam int unsigned CmpW  = 14;

endpackage

### hw/rtl/depth_backproject_rgb_register_core.sv
// Depth pixel back-projection with registration into the color frame. One pixel request
// is taken every clock (busy is held low) and its result passes through stages 1 to 5,
// the column divider stages and the registered output stage to the result ports, marked
// by a one-cycle result_valid_o strobe; the receiver cannot stall, so it must capture
// each result in that cycle. The color column divider is a restoring divider that
// resolves one quotient bit per pipeline stage, behind four multiply stages. The user
// must write depth_max_mm through cfg_we_i/cfg_wdata_i only while no request is in
// flight; the block itself does not enforce this.
module depth_backproject_rgb_register_core
  import dbpr_pkg::*;
#(
  parameter int unsigned DEPTH_WIDTH  = DepthWidthDef,
  parameter int unsigned DEPTH_HEIGHT = DepthHeightDef,
  parameter int unsigned COLOR_WIDTH  = ColorWidthDef,
  parameter int unsigned COLOR_HEIGHT = ColorHeightDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [RowInW-1:0]               pixel_row_i,
  input  logic [ColInW-1:0]               pixel_col_i,
  input  logic [DepthW-1:0]               depth_raw_i,
  input  logic                            cfg_we_i,
  input  logic [CfgW-1:0]                 cfg_wdata_i,
  output logic                            result_valid_o,
  output logic                            point_valid_o,
  output logic [PosW-1:0]                 pos_x_o,
  output logic [PosW-1:0]                 pos_y_o,
  output logic [DepthW-1:0]               pos_z_o,
  output logic                            color_hit_o,
  output logic [$clog2(COLOR_WIDTH)-1:0]  color_col_o,
  output logic [$clog2(COLOR_HEIGHT)-1:0] color_row_o
);

  localparam int unsigned ColQw  = $clog2(COLOR_WIDTH);
  localparam int unsigned RowOw  = $clog2(COLOR_HEIGHT);
  localparam int unsigned VldLen = ColQw + 5;

  localparam logic [MagW:0]    XCenter2  = (MagW + 1)'(DEPTH_WIDTH - 1);
  localparam logic [MagW:0]    YCenter2  = (MagW + 1)'(DEPTH_HEIGHT - 1);
  localparam logic [AW-1:0]    AOffset   = AW'(CenterStep * (DEPTH_WIDTH - 1));
  localparam logic [NumrW-1:0] RowOffset = NumrW'(CenterStep * (DEPTH_HEIGHT - 1));

  typedef struct packed {
    logic              pv;
    logic              xneg;
    logic [MagW-1:0]   xmag;
    logic              yneg;
    logic [MagW-1:0]   ymag;
    logic [DepthW-1:0] d;
    logic [AW-1:0]     a;
    logic [NumrW-1:0]  numr;
  } s1_t;

  typedef struct packed {
    logic                pv;
    logic                xneg;
    logic                yneg;
    logic [DepthW-1:0]   d;
    logic [ProdW-1:0]    px;
    logic [ProdW-1:0]    py;
    logic [NumcW-1:0]    numc;
    logic [DenW-1:0]     den;
    logic [RowProdW-1:0] rprod;
  } s2_t;

  typedef struct packed {
    logic               pv;
    logic               xneg;
    logic               yneg;
    logic               xsat;
    logic               ysat;
    logic [DepthW-1:0]  d;
    logic [NarrowW-1:0] nx;
    logic [NarrowW-1:0] ny;
    logic [NumcW-1:0]   numc;
    logic [DenW-1:0]    den;
    logic [CrW-1:0]     cr;
    logic               row_ok;
    logic               ovf;
  } s3_t;

  typedef struct packed {
    logic              pv;
    logic              xneg;
    logic              yneg;
    logic              xsat;
    logic              ysat;
    logic [DepthW-1:0] d;
    logic [QPosW-1:0]  qx;
    logic [QPosW-1:0]  qy;
    logic [NumcW-1:0]  numc;
    logic [DenW-1:0]   den;
    logic [CrW-1:0]    cr;
    logic              row_ok;
    logic              ovf;
  } s4_t;

  typedef struct packed {
    logic              pv;
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
    logic [DepthW-1:0] d;
    logic [CrW-1:0]    cr;
    logic              row_ok;
    logic              ovf;
    logic [DivW-1:0]   rem;
    logic [DenW-1:0]   den;
    logic [ColQw-1:0]  q;
  } dv_t;

  logic              accept;
  logic [CfgW-1:0]   depth_max_q;
  logic [VldLen-1:0] vld_q;
  s1_t               s1_d, s1_q;
  s2_t               s2_d, s2_q;
  s3_t               s3_d, s3_q;
  s4_t               s4_d, s4_q;
  dv_t               dv0_d;
  dv_t               dv_q [0:ColQw];

  // The pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Depth limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_max_q <= DepthMaxReset;
    end else if (cfg_we_i) begin
      depth_max_q <= cfg_wdata_i;
    end
  end

  // Valid bits, one per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      vld_q          <= {vld_q[VldLen-2:0], accept};
      result_valid_o <= vld_q[VldLen-1];
    end
  end

  // Stage 1: validity, centered offsets, color numerator bases
  always_comb begin
    logic [MagW:0] c2, r2, dxa, dya;
    c2 = {2'b00, pixel_col_i, 1'b0};
    r2 = {3'b000, pixel_row_i, 1'b0};
    s1_d.pv = (depth_raw_i != '0) &&
              ((depth_max_q == '0) || (depth_raw_i <= DepthW'(depth_max_q)));
    s1_d.xneg = c2 < XCenter2;
    s1_d.yneg = r2 < YCenter2;
    dxa = s1_d.xneg ? (XCenter2 - c2) : (c2 - XCenter2);
    dya = s1_d.yneg ? (YCenter2 - r2) : (r2 - YCenter2);
    s1_d.xmag = dxa[MagW-1:0];
    s1_d.ymag = dya[MagW-1:0];
    s1_d.d    = depth_raw_i;
    s1_d.a    = AW'(pixel_col_i) * AW'(ColStep) + AOffset;
    s1_d.numr = NumrW'(pixel_row_i) * NumrW'(ColStep) + RowOffset;
  end

  // Stage 2: products with depth, row reciprocal multiply
  always_comb begin
    s2_d.pv    = s1_q.pv;
    s2_d.xneg  = s1_q.xneg;
    s2_d.yneg  = s1_q.yneg;
    s2_d.d     = s1_q.d;
    s2_d.px    = ProdW'(s1_q.xmag) * ProdW'(s1_q.d);
    s2_d.py    = ProdW'(s1_q.ymag) * ProdW'(s1_q.d);
    s2_d.numc  = NumcW'(s1_q.a) * NumcW'(s1_q.d) + NumcW'(BaselineNum);
    s2_d.den   = DenW'(s1_q.d) * DenW'(FocalTenths);
    s2_d.rprod = RowProdW'(s1_q.numr) * RowProdW'(RecipRow);
  end

  // Stage 3: scale and bias positions, saturation test, row and overflow checks
  always_comb begin
    logic [ScaledW-1:0] sx, sy;
    sx = ScaledW'(s2_q.px) * ScaledW'(PosScale) + ScaledW'(RoundBias);
    sy = ScaledW'(s2_q.py) * ScaledW'(PosScale) + ScaledW'(RoundBias);
    s3_d.pv     = s2_q.pv;
    s3_d.xneg   = s2_q.xneg;
    s3_d.yneg   = s2_q.yneg;
    s3_d.xsat   = sx >= SatThresh;
    s3_d.ysat   = sy >= SatThresh;
    s3_d.d      = s2_q.d;
    s3_d.nx     = sx[NarrowW-1:0];
    s3_d.ny     = sy[NarrowW-1:0];
    s3_d.numc   = s2_q.numc;
    s3_d.den    = s2_q.den;
    s3_d.cr     = s2_q.rprod[RecipRowShift +: CrW];
    s3_d.row_ok = CmpW'(s3_d.cr) < CmpW'(COLOR_HEIGHT);
    // quotient would not fit the column divider
    s3_d.ovf    = DivW'(s2_q.numc) >= (DivW'(s2_q.den) << ColQw);
  end

  // Stage 4: divide positions by 5758 through the reciprocal
  always_comb begin
    logic [NarrowW+RecipPosW-1:0] qpx, qpy;
    qpx = (NarrowW + RecipPosW)'(s3_q.nx) * (NarrowW + RecipPosW)'(RecipPos);
    qpy = (NarrowW + RecipPosW)'(s3_q.ny) * (NarrowW + RecipPosW)'(RecipPos);
    s4_d.pv     = s3_q.pv;
    s4_d.xneg   = s3_q.xneg;
    s4_d.yneg   = s3_q.yneg;
    s4_d.xsat   = s3_q.xsat;
    s4_d.ysat   = s3_q.ysat;
    s4_d.d      = s3_q.d;
    s4_d.qx     = qpx[RecipPosShift +: QPosW];
    s4_d.qy     = qpy[RecipPosShift +: QPosW];
    s4_d.numc   = s3_q.numc;
    s4_d.den    = s3_q.den;
    s4_d.cr     = s3_q.cr;
    s4_d.row_ok = s3_q.row_ok;
    s4_d.ovf    = s3_q.ovf;
  end

  // Stage 5: saturate and sign positions, load the column divider
  always_comb begin
    logic [QPosW-1:0] qx, qy;
    qx = s4_q.xsat ? QPosW'(PosLimit) : s4_q.qx;
    qy = s4_q.ysat ? QPosW'(PosLimit) : s4_q.qy;
    dv0_d.pv     = s4_q.pv;
    dv0_d.pos_x  = s4_q.xneg ? (PosW'(0) - PosW'(qx)) : PosW'(qx);
    dv0_d.pos_y  = s4_q.yneg ? (PosW'(0) - PosW'(qy)) : PosW'(qy);
    dv0_d.d      = s4_q.d;
    dv0_d.cr     = s4_q.cr;
    dv0_d.row_ok = s4_q.row_ok;
    dv0_d.ovf    = s4_q.ovf;
    dv0_d.rem    = DivW'(s4_q.numc);
    dv0_d.den    = s4_q.den;
    dv0_d.q      = '0;
  end

  // Pipeline payload registers
  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    s2_q     <= s2_d;
    s3_q     <= s3_d;
    s4_q     <= s4_d;
    dv_q[0]  <= dv0_d;
  end

  // Restoring divider, one quotient bit per stage, MSB first
  for (genvar k = 1; k <= ColQw; k++) begin : g_div
    localparam int unsigned Bit = ColQw - k;
    dv_t             dv_d;
    logic [DivW-1:0] sden;

    always_comb begin
      sden = DivW'(dv_q[k-1].den) << Bit;
      dv_d = dv_q[k-1];
      if (dv_q[k-1].rem >= sden) begin
        dv_d.rem    = dv_q[k-1].rem - sden;
        dv_d.q[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[k] <= dv_d;
    end
  end

  // Output stage: frame test, zero fields of invalid points and misses
  always_ff @(posedge clk_i) begin
    logic hit;
    hit = dv_q[ColQw].pv && !dv_q[ColQw].ovf && dv_q[ColQw].row_ok &&
          ((ColQw + 1)'(dv_q[ColQw].q) < (ColQw + 1)'(COLOR_WIDTH));
    point_valid_o <= dv_q[ColQw].pv;
    pos_x_o       <= dv_q[ColQw].pv ? dv_q[ColQw].pos_x : '0;
    pos_y_o       <= dv_q[ColQw].pv ? dv_q[ColQw].pos_y : '0;
    pos_z_o       <= dv_q[ColQw].pv ? dv_q[ColQw].d : '0;
    color_hit_o   <= hit;
    color_col_o   <= hit ? dv_q[ColQw].q : '0;
    color_row_o   <= hit ? RowOw'(dv_q[ColQw].cr) : '0;
  end

endmodule

### hw/rtl/dbpr_checker.sv
module dbpr_checker
  import dbpr_pkg::*;
#(
  parameter int unsigned COLOR_WIDTH  = ColorWidthDef,
  parameter int unsigned COLOR_HEIGHT = ColorHeightDef
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            result_valid_o,
  input logic                            point_valid_o,
  input logic [PosW-1:0]                 pos_x_o,
  input logic [PosW-1:0]                 pos_y_o,
  input logic [DepthW-1:0]               pos_z_o,
  input logic                            color_hit_o,
  input logic [$clog2(COLOR_WIDTH)-1:0]  color_col_o,
  input logic [$clog2(COLOR_HEIGHT)-1:0] color_row_o
);

  localparam logic signed [PosW-1:0] PosMax = PosW'(PosLimit);
  localparam logic signed [PosW-1:0] PosMin = -PosMax;

  // An invalid point carries all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !point_valid_o |->
      pos_x_o == '0 && pos_y_o == '0 && pos_z_o == '0 && !color_hit_o &&
      color_col_o == '0 && color_row_o == '0)
    else $error("invalid point with nonzero fields");

  // A valid point has a measured depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && point_valid_o |-> pos_z_o != '0)
    else $error("valid point with zero depth");

  // A color hit needs a valid point and lands inside the color frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && color_hit_o |->
      point_valid_o && (32'(color_col_o) < COLOR_WIDTH) &&
      (32'(color_row_o) < COLOR_HEIGHT))
    else $error("color hit outside frame or on invalid point");

  // Positions stay within the saturation limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      $signed(pos_x_o) <= PosMax && $signed(pos_x_o) >= PosMin &&
      $signed(pos_y_o) <= PosMax && $signed(pos_y_o) >= PosMin)
    else $error("position beyond saturation limit");

endmodule

bind depth_backproject_rgb_register_core dbpr_checker #(
  .COLOR_WIDTH (COLOR_WIDTH),
  .COLOR_HEIGHT(COLOR_HEIGHT)
) u_dbpr_checker (.*);
